[rtl/u8bd_pkg.sv]
// Shared types and constants for the UTF-8 BMP stream decoder.
package u8bd_pkg;

  // Byte classification masks and tags
  localparam logic [7:0] CONT_MASK  = 8'hC0;
  localparam logic [7:0] CONT_TAG   = 8'h80;
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_TAG  = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_TAG  = 8'hE0;
  localparam logic [7:0] PAY2_MASK  = 8'h1F;
  localparam logic [7:0] PAY3_MASK  = 8'h0F;
  localparam logic [7:0] PAYC_MASK  = 8'h3F;

  // Code point limits for overlong and surrogate checks
  localparam logic [15:0] MIN_TWO   = 16'h0080;
  localparam logic [15:0] MIN_THREE = 16'h0800;
  localparam logic [15:0] SURR_LO   = 16'hD800;
  localparam logic [15:0] SURR_HI   = 16'hDFFF;

  // Pending continuation counts and sequence lengths
  localparam logic [1:0] PEND_NONE = 2'd0;
  localparam logic [1:0] PEND_ONE  = 2'd1;
  localparam logic [1:0] PEND_TWO  = 2'd2;
  localparam logic [1:0] LEN_NONE  = 2'd0;
  localparam logic [1:0] LEN_TWO   = 2'd2;
  localparam logic [1:0] LEN_THREE = 2'd3;

  // One classified input transaction, queued for the back end
  typedef struct packed {
    logic        cp_vld;   // a code point result is carried
    logic [15:0] cp;
    logic        eos;      // a status result follows
    logic        err;      // status: encoding error
  } u8bd_entry_t;

endpackage

[rtl/u8bd_if.sv]
// Stream interfaces for the byte input and the code point output.
interface u8bd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       string_end;

  modport source (output valid, output data_byte, output has_byte, output string_end,
                  input ready);
  modport sink   (input valid, input data_byte, input has_byte, input string_end,
                  output ready);
endinterface

interface u8bd_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_point;
  logic        end_of_string;
  logic        encoding_error;

  modport source (output valid, output code_point, output end_of_string,
                  output encoding_error, input ready);
  modport sink   (input valid, input code_point, input end_of_string,
                  input encoding_error, output ready);
endinterface

[rtl/u8bd_front.sv]
// Front end: accepts bytes, runs the UTF-8 decode state and queues results.
module u8bd_front
  import u8bd_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  u8bd_in_if.sink      in_i,
  input  logic         full_i,
  output logic         push_o,
  output u8bd_entry_t  entry_o
);

  logic [1:0]  pend_q, pend_d;
  logic [15:0] part_q, part_d;
  logic [1:0]  len_q, len_d;
  logic        err_q, err_d;
  logic [7:0]  b;
  logic [15:0] v;
  logic        bad;
  logic        acc;

  assign b          = in_i.data_byte;
  assign in_i.ready = !full_i;
  assign acc        = in_i.valid && !full_i;
  assign v          = part_q | {10'd0, b[5:0]};

  // Decode step for one byte, then end-of-string handling
  always_comb begin
    pend_d        = pend_q;
    part_d        = part_q;
    len_d         = len_q;
    err_d         = err_q;
    bad           = 1'b0;
    entry_o       = '0;
    if (in_i.has_byte && !err_q) begin
      if (pend_q == PEND_NONE) begin
        if ((b & CONT_TAG) == 8'h00) begin
          entry_o.cp_vld = 1'b1;
          entry_o.cp     = {8'h00, b};
        end else if ((b & LEAD2_MASK) == LEAD2_TAG) begin
          part_d = {5'd0, b[4:0], 6'd0} & {5'd0, PAY2_MASK[4:0], 6'd0};
          pend_d = PEND_ONE;
          len_d  = LEN_TWO;
        end else if ((b & LEAD3_MASK) == LEAD3_TAG) begin
          part_d = {b[3:0], 12'd0} & {PAY3_MASK[3:0], 12'd0};
          pend_d = PEND_TWO;
          len_d  = LEN_THREE;
        end else begin
          bad = 1'b1;
        end
      end else if ((b & CONT_MASK) != CONT_TAG) begin
        bad = 1'b1;
      end else if (pend_q == PEND_TWO) begin
        part_d = part_q | {4'd0, b[5:0] & PAYC_MASK[5:0], 6'd0};
        pend_d = PEND_ONE;
      end else begin
        // last continuation: range checks on the finished value
        if (len_q == LEN_THREE) begin
          bad = (v < MIN_THREE) || ((v >= SURR_LO) && (v <= SURR_HI));
        end else begin
          bad = (v < MIN_TWO);
        end
        if (!bad) begin
          pend_d         = PEND_NONE;
          part_d         = '0;
          len_d          = LEN_NONE;
          entry_o.cp_vld = 1'b1;
          entry_o.cp     = v;
        end
      end
      if (bad) begin
        err_d  = 1'b1;
        pend_d = PEND_NONE;
        part_d = '0;
        len_d  = LEN_NONE;
      end
    end
    // status transaction closes the string and clears the state
    if (in_i.string_end) begin
      entry_o.eos = 1'b1;
      entry_o.err = err_d || (pend_d != PEND_NONE);
      pend_d      = PEND_NONE;
      part_d      = '0;
      len_d       = LEN_NONE;
      err_d       = 1'b0;
    end
    push_o = acc && (entry_o.cp_vld || entry_o.eos);
  end

  // Decoder state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= PEND_NONE;
      part_q <= '0;
      len_q  <= LEN_NONE;
      err_q  <= 1'b0;
    end else if (acc) begin
      pend_q <= pend_d;
      part_q <= part_d;
      len_q  <= len_d;
      err_q  <= err_d;
    end
  end

endmodule

[rtl/u8bd_fifo.sv]
// Short queue of classified entries between the front and back ends.
module u8bd_fifo
  import u8bd_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  u8bd_entry_t  wdata_i,
  output logic         full_o,
  input  logic         pop_i,
  output u8bd_entry_t  rdata_o,
  output logic         empty_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

  u8bd_entry_t   mem_q [DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_q];

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == LAST) ? '0 : wr_q + PW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == LAST) ? '0 : rd_q + PW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

endmodule

[rtl/u8bd_back.sv]
// Back end: splits queued entries into result transactions on an output register.
module u8bd_back
  import u8bd_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  u8bd_entry_t  head_i,
  input  logic         empty_i,
  output logic         pop_o,
  u8bd_out_if.source   out_o
);

  logic        vld_q, vld_d;
  logic        sent_q, sent_d;   // code point of the head already sent
  logic [15:0] cp_q, cp_d;
  logic        eos_q, eos_d;
  logic        err_q, err_d;
  logic        load;

  assign load = !vld_q || out_o.ready;

  // Pick the next result from the queue head
  always_comb begin
    vld_d  = vld_q;
    sent_d = sent_q;
    cp_d   = cp_q;
    eos_d  = eos_q;
    err_d  = err_q;
    pop_o  = 1'b0;
    if (load) begin
      vld_d = !empty_i;
      if (!empty_i) begin
        if (head_i.cp_vld && !sent_q) begin
          cp_d  = head_i.cp;
          eos_d = 1'b0;
          err_d = 1'b0;
          if (head_i.eos) begin
            sent_d = 1'b1;
          end else begin
            pop_o = 1'b1;
          end
        end else begin
          cp_d   = '0;
          eos_d  = 1'b1;
          err_d  = head_i.err;
          sent_d = 1'b0;
          pop_o  = 1'b1;
        end
      end
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= 1'b0;
      sent_q <= 1'b0;
    end else begin
      vld_q  <= vld_d;
      sent_q <= sent_d;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    cp_q  <= cp_d;
    eos_q <= eos_d;
    err_q <= err_d;
  end

  assign out_o.valid          = vld_q;
  assign out_o.code_point     = cp_q;
  assign out_o.end_of_string  = eos_q;
  assign out_o.encoding_error = err_q;

endmodule

[rtl/utf8_bmp_stream_decoder_top.sv]
// UTF-8 to BMP code point stream decoder, one byte per cycle.
// A result passes through the entry queue and then the output register before it appears.
// Input transactions are taken one per cycle while the queue is not full; a byte that
// completes a code point and also ends the string yields two results, sent one after the other.
// Input is held off only while the entry queue (FIFO_DEPTH entries) is full.
// Reset clears the decoder state, the queue pointers and the output valid.
module utf8_bmp_stream_decoder_top
  import u8bd_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  u8bd_in_if.sink     in_i,
  u8bd_out_if.source  out_o
);

  u8bd_entry_t wr_entry, head;
  logic        push, full, pop, empty;

  u8bd_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .full_i  (full),
    .push_o  (push),
    .entry_o (wr_entry)
  );

  u8bd_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (wr_entry),
    .full_o  (full),
    .pop_i   (pop),
    .rdata_o (head),
    .empty_o (empty)
  );

  u8bd_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .head_i  (head),
    .empty_i (empty),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule
